// ===== sv/pafp_pkg.sv =====
// Package: constants and types for the focusing phase core
`timescale 1ns / 1ps
package pafp_pkg;
    localparam int GRID_SIDE = 8;
    localparam int PHASE_WORDS = 16;
    localparam int NCH = GRID_SIDE * GRID_SIDE;
    localparam int CH_W = $clog2(4 * PHASE_WORDS);
    localparam int WI_W = $clog2(PHASE_WORDS);
    localparam int GS_W = $clog2(GRID_SIDE);
    localparam logic [15:0] WAVELENGTH_RESET = 16'd34846;
    localparam logic [11:0] LAST_X_RESET = 12'd1056;
    localparam logic [11:0] LAST_Y_RESET = 12'd1056;
    localparam logic [11:0] LAST_Z_RESET = 12'd1600;
    localparam int ELEM_OFFSET = 132;
    localparam int ELEM_PITCH = 264;
    localparam logic [11:0] PLANE_Z = 12'd192;
    localparam int SQ_W = 48;
    localparam int RT_W = 24;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ,
        ST_ROOT,
        ST_MOD,
        ST_DIVSET,
        ST_DIV,
        ST_PACK,
        ST_OUT
    } state_t;
endpackage

// ===== sv/phased_array_focus_phase_core.sv =====
// Top level: focusing phase delays for an 8x8 transducer grid
`timescale 1ns / 1ps
// Usage: a focal point transfer on focus_x/y/z (valid/ready) starts a pass over all
// channels unless it equals the previous focal point, in which case it is dropped
// with no output. Each pass emits PHASE_WORDS transfers on the output channel
// (reg_index, phase_word, last), four channel phases per word, lowest channel low.
// Per channel: an offset step, three squares on one shared multiplier, a 24-step
// restoring square root, a 24-step remainder by the wavelength, a set-up step,
// a 10-step quotient for the phase and a packing step. After four channels the
// word is offered; each further word is computed after the previous one is taken.
// The block takes no new point until the last word of a pass is transferred.
// A stalled receiver holds the current word; work halts until it is taken.
// The wavelength register is written by a transfer on cfg_valid/cfg_ready,
// only while idle. Reset (rst_n low, asynchronous) restores wavelength 34846
// and last point (1056, 1056, 1600).
module phased_array_focus_phase_core
    import pafp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] focus_x,
    input  logic [11:0] focus_y,
    input  logic [11:0] focus_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  reg_index,
    output logic [31:0] phase_word,
    output logic        last
);
    state_t state_reg, state_next;
    logic [15:0] wl_reg;
    logic [11:0] lx_reg, ly_reg, lz_reg;
    logic [CH_W-1:0] ch_reg;
    logic [1:0] sq_reg;
    logic [12:0] dx_reg, dy_reg, dz_reg;
    logic [SQ_W-1:0] acc_reg;
    logic [SQ_W-1:0] rem_reg;
    logic [RT_W-1:0] root_reg;
    logic [4:0] step_reg;
    logic [RT_W:0] r_reg;
    logic [26:0] num_reg;
    logic [16:0] wle;
    logic [9:0] q_reg;
    logic [23:0] buf_reg;
    logic [31:0] word_reg;
    logic [WI_W-1:0] widx_reg;
    logic [7:0] ph;
    logic [12:0] ex, ey;
    logic [12:0] mop;
    logic [25:0] prod;
    logic [SQ_W+1:0] trial;
    logic [RT_W:0] rsh;
    logic in_grid;

    assign wle = (wl_reg == 16'd0) ? 17'd1 : {1'b0, wl_reg};
    assign in_grid = 32'(ch_reg) < NCH;
    assign ex = 13'(ELEM_OFFSET + ELEM_PITCH * 32'(ch_reg / GRID_SIDE));
    assign ey = 13'(ELEM_OFFSET + ELEM_PITCH * 32'(ch_reg % GRID_SIDE));
    assign mop = (sq_reg == 2'd0) ? dx_reg : (sq_reg == 2'd1) ? dy_reg : dz_reg;
    assign prod = mop * mop;
    // root step: two bits of radicand per cycle
    assign trial = {rem_reg, acc_reg[SQ_W-1 -: 2]} - {root_reg, 2'b01};
    assign rsh = {r_reg[RT_W-1:0], 1'b0};

    always_comb
    begin
        logic [8:0] q9;
        q9 = q_reg[9:1];
        ph = q9[7:0];
        if (!in_grid)
            ph = 8'd0;
        else if (32'(ch_reg) >= NCH / 2)
            ph = ph + 8'd128;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid && !(focus_x == lx_reg && focus_y == ly_reg && focus_z == lz_reg))
                    state_next = ST_DIFF;
            ST_DIFF:   state_next = in_grid ? ST_SQ : ST_PACK;
            ST_SQ:     if (sq_reg == 2'd2) state_next = ST_ROOT;
            ST_ROOT:   if (step_reg == 5'(RT_W - 1)) state_next = ST_MOD;
            ST_MOD:    if (step_reg == 5'(RT_W - 1)) state_next = ST_DIVSET;
            ST_DIVSET: state_next = ST_DIV;
            ST_DIV:    if (step_reg == 5'd9) state_next = ST_PACK;
            ST_PACK:   if (ch_reg[1:0] == 2'd3) state_next = ST_OUT; else state_next = ST_DIFF;
            ST_OUT:
                if (out_ready)
                    state_next = (widx_reg == WI_W'(PHASE_WORDS - 1)) ? ST_IDLE : ST_DIFF;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        cfg_ready = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
    end

    assign reg_index = 4'(widx_reg);
    assign phase_word = word_reg;
    assign last = (widx_reg == WI_W'(PHASE_WORDS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wl_reg <= WAVELENGTH_RESET;
            lx_reg <= LAST_X_RESET;
            ly_reg <= LAST_Y_RESET;
            lz_reg <= LAST_Z_RESET;
            ch_reg <= '0;
            widx_reg <= '0;
            sq_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                wl_reg <= cfg_data;
            case (state_reg)
                ST_IDLE:
                    if (state_next == ST_DIFF)
                    begin
                        lx_reg <= focus_x;
                        ly_reg <= focus_y;
                        lz_reg <= focus_z;
                        ch_reg <= '0;
                        widx_reg <= '0;
                    end
                ST_DIFF:   sq_reg <= '0;
                ST_SQ:     sq_reg <= sq_reg + 2'd1;
                ST_ROOT:   step_reg <= (state_next == ST_MOD) ? 5'd0 : step_reg + 5'd1;
                ST_MOD:    step_reg <= (state_next == ST_DIVSET) ? 5'd0 : step_reg + 5'd1;
                ST_DIV:    step_reg <= (state_next == ST_PACK) ? 5'd0 : step_reg + 5'd1;
                ST_PACK:   ch_reg <= ch_reg + 1'b1;
                ST_OUT:    if (out_ready) widx_reg <= widx_reg + 1'b1;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_DIFF:
            begin
                dx_reg <= ({1'b0, lx_reg} >= ex) ? {1'b0, lx_reg} - ex : ex - {1'b0, lx_reg};
                dy_reg <= ({1'b0, ly_reg} >= ey) ? {1'b0, ly_reg} - ey : ey - {1'b0, ly_reg};
                dz_reg <= (lz_reg >= PLANE_Z) ? {1'b0, lz_reg - PLANE_Z}
                                              : {1'b0, PLANE_Z - lz_reg};
                acc_reg <= '0;
                q_reg <= '0;
            end
            ST_SQ:
            begin
                acc_reg <= (sq_reg == 2'd2) ? {acc_reg[SQ_W-17:0] + 32'(prod), 16'd0}
                                            : acc_reg + SQ_W'(prod);
                rem_reg <= '0;
                root_reg <= '0;
            end
            ST_ROOT:
            begin
                if (!trial[SQ_W+1])
                begin
                    rem_reg <= trial[SQ_W-1:0];
                    root_reg <= {root_reg[RT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[SQ_W-3:0], acc_reg[SQ_W-1 -: 2]};
                    root_reg <= {root_reg[RT_W-2:0], 1'b0};
                end
                acc_reg <= {acc_reg[SQ_W-3:0], 2'b00};
                r_reg <= '0;
            end
            ST_MOD:
            begin
                // restoring remainder of root by wavelength, one bit per cycle
                if ((rsh | (RT_W+1)'(root_reg[RT_W-1])) >= (RT_W+1)'(wle))
                    r_reg <= (rsh | (RT_W+1)'(root_reg[RT_W-1])) - (RT_W+1)'(wle);
                else
                    r_reg <= rsh | (RT_W+1)'(root_reg[RT_W-1]);
                root_reg <= {root_reg[RT_W-2:0], 1'b0};
            end
            ST_DIVSET:
                num_reg <= 27'(((27'(wle) - 27'(r_reg)) << 9) + 27'(wle)) ;
            ST_DIV:
            begin
                // quotient of num by wl, top bits first (q < 1024)
                if ((28'(num_reg) >> (9 - step_reg)) >= 28'(wle))
                begin
                    q_reg <= q_reg | (10'd1 << (9 - step_reg));
                    num_reg <= num_reg - 27'(28'(wle) << (9 - step_reg));
                end
            end
            ST_PACK:
                case (ch_reg[1:0])
                    2'd0: buf_reg[7:0] <= ph;
                    2'd1: buf_reg[15:8] <= ph;
                    2'd2: buf_reg[23:16] <= ph;
                    default: word_reg <= {ph, buf_reg};
                endcase
            default: ;
        endcase
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phase_word) && $stable(reg_index))
        else $error("output word changed while stalled");
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken during a pass");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> state_reg == ST_IDLE)
        else $error("pass did not end after last word");
endmodule
